FILE: rtl/brainfuck_interpreter_core_assert.svh
`ifndef BRAINFUCK_INTERPRETER_CORE_ASSERT_SVH
`define BRAINFUCK_INTERPRETER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BFI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/bfi_pkg.sv
`default_nettype none
package bfi_pkg;
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BRACKET = 3'd4,
    ST_STACK   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN,
    S_FETCH,
    S_EXEC,
    S_CELL,
    S_WRITE,
    S_POP,
    S_SKIP_RD,
    S_SKIP,
    S_OUT
  } fsm_e;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_char;
    logic [2:0]  status;
    logic [12:0] program_counter;
    logic [14:0] tape_pointer;
  } result_t;
endpackage
`default_nettype wire

FILE: rtl/bfi_mem.sv
`default_nettype none
module bfi_mem #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/brainfuck_interpreter_core.sv
// channel  | dir | tdata fields (low bit up)                                    | tuser
// s_axis   | in  | op[1:0], load_address[13:2], load_byte[21:14] (24 bits)       | -
// m_axis   | out | out_valid[0], out_char[8:1], status[11:9],
//          |     | program_counter[24:12], tape_pointer[39:25] (40 bits)         | -
// cfg      | in  | program_length[12:0], written when cfg_we_i is high           | -
// a load, an unknown op or a step while stopped goes from idle to S_OUT, and its result
// is registered from there; a running step goes through program memory read, tape memory
// read and, for '+' or '-', write back; a '[' on a zero cell then scans byte by byte.
// restart runs a tape clearing pass over all TAPE_DEPTH cells plus a bracket scan
// over the program bytes; after reset the same clearing pass runs once.
// the next transaction is taken once the result register is free again.
`default_nettype none
module brainfuck_interpreter_core
  import bfi_pkg::*;
#(
  parameter int PROG_DEPTH  = 4096,
  parameter int TAPE_DEPTH  = 32768,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // op, load_address, load_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,  // out_valid, out_char, status, pc, pointer
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i
);
  localparam int PW = $clog2(PROG_DEPTH);
  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int LW = $clog2(PROG_DEPTH + 1);
  localparam int CW = LW + 1;

  fsm_e state_q, state_d;
  logic [12:0]   plen_q;
  logic [LW-1:0] len;
  logic [CW-1:0] pc_q, pc_d, idx_q, idx_d, depth_q, depth_d;
  logic [TW:0]   dp_q, dp_d;
  logic [TW:0]   clr_q, clr_d;
  logic [DW-1:0] sp_q, sp_d;
  logic [2:0]    st_q, st_d;
  logic [7:0]    cmd_q, cmd_d;
  logic          busy_q, busy_d, mval_q, mval_d, fresh_q, fresh_d;
  result_t       res_q, res_d;
  logic [1:0]    in_op;
  logic [11:0]   in_addr;
  logic [7:0]    in_byte;

  assign in_op   = s_axis_tdata[1:0];
  assign in_addr = s_axis_tdata[13:2];
  assign in_byte = s_axis_tdata[21:14];

  // program length clipped to the store
  assign len = (32'(plen_q) > 32'(PROG_DEPTH)) ? LW'(PROG_DEPTH) : LW'(plen_q);

  // memories
  logic          p_we, t_we, k_we;
  logic [PW-1:0] p_wa, p_ra;
  logic [7:0]    p_wd, p_rd, t_wd, t_rd;
  logic [TW-1:0] t_wa, t_ra;
  logic [SW-1:0] k_wa, k_ra;
  logic [PW-1:0] k_wd, k_rd;

  bfi_mem #(.Depth(PROG_DEPTH), .Width(8)) u_prog (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  bfi_mem #(.Depth(TAPE_DEPTH), .Width(8)) u_tape (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  bfi_mem #(.Depth(STACK_DEPTH), .Width(PW)) u_stack (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(k_ra), .rdata_o(k_rd));

  logic accept, out_take;
  assign s_axis_tready = (state_q == S_IDLE) && !mval_q && !busy_q;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {res_q.tape_pointer, res_q.program_counter, res_q.status,
                          res_q.out_char, res_q.out_valid};

  logic [CW-1:0] pc_inc;
  assign pc_inc = pc_q + CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (busy_q) state_d = S_CLEAR;
        else if (accept) begin
          unique case (in_op)
            OP_STEP:    state_d = (st_q == ST_RUN) ? S_FETCH : S_OUT;
            OP_RESTART: state_d = S_CLEAR;
            default:    state_d = S_OUT;
          endcase
        end
      end
      S_CLEAR:   if (clr_q == (TW+1)'(TAPE_DEPTH - 1))
                   state_d = fresh_q ? S_SCAN_RD : S_IDLE;
      S_SCAN_RD: state_d = (idx_q >= CW'(len)) ? S_OUT : S_SCAN;
      S_SCAN:    state_d = S_SCAN_RD;
      S_FETCH:   state_d = (pc_q >= CW'(len)) ? S_OUT : S_EXEC;
      S_EXEC:    state_d = S_CELL;
      S_CELL: begin
        if ((cmd_q == ChPlus) || (cmd_q == ChMinus)) state_d = S_WRITE;
        else if ((cmd_q == ChOpen) && (t_rd == 8'd0)) state_d = S_SKIP_RD;
        else if ((cmd_q == ChClose) && (sp_q != '0) && (t_rd != 8'd0)) state_d = S_POP;
        else state_d = S_OUT;
      end
      S_WRITE:   state_d = S_OUT;
      S_POP:     state_d = S_OUT;
      S_SKIP_RD: state_d = (idx_q >= CW'(len)) ? S_OUT : S_SKIP;
      S_SKIP:    state_d = S_SKIP_RD;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
    if ((state_q == S_SKIP) && (p_rd == ChClose) && (depth_q == CW'(1))) state_d = S_OUT;
    if ((state_q == S_SCAN) && (p_rd == ChClose) && (depth_q == '0)) state_d = S_OUT;
  end

  // datapath
  always_comb begin
    pc_d = pc_q; dp_d = dp_q; sp_d = sp_q; st_d = st_q; idx_d = idx_q;
    depth_d = depth_q; clr_d = clr_q; cmd_d = cmd_q; busy_d = busy_q;
    fresh_d = fresh_q; mval_d = mval_q; res_d = res_q;
    p_we = 1'b0; p_wa = PW'(in_addr); p_wd = in_byte;
    p_ra = pc_q[PW-1:0];
    t_we = 1'b0; t_wa = dp_q[TW-1:0]; t_wd = 8'd0; t_ra = dp_q[TW-1:0];
    k_we = 1'b0; k_wa = sp_q[SW-1:0]; k_wd = pc_q[PW-1:0];
    k_ra = SW'(sp_q - DW'(1));
    if (out_take) mval_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.out_valid = 1'b0;
          res_d.out_char  = 8'd0;
        end
        if (accept && (in_op == OP_LOAD) && (32'(in_addr) < 32'(PROG_DEPTH)))
          p_we = 1'b1;
        if (accept && (in_op == OP_RESTART)) begin
          clr_d = '0; fresh_d = 1'b1;
          pc_d = '0; dp_d = '0; sp_d = '0;
        end
      end
      S_CLEAR: begin
        t_we = 1'b1; t_wa = clr_q[TW-1:0];
        clr_d = clr_q + (TW+1)'(1);
        if (clr_q == (TW+1)'(TAPE_DEPTH - 1)) begin
          busy_d = 1'b0; idx_d = '0; depth_d = '0; st_d = ST_RUN;
        end
      end
      S_SCAN_RD: begin
        p_ra = idx_q[PW-1:0];
        if (idx_q >= CW'(len)) st_d = (depth_q != '0) ? ST_BRACKET : ST_RUN;
      end
      S_SCAN: begin
        idx_d = idx_q + CW'(1);
        if (p_rd == ChOpen) depth_d = depth_q + CW'(1);
        else if (p_rd == ChClose) begin
          if (depth_q == '0) st_d = ST_BRACKET;
          else depth_d = depth_q - CW'(1);
        end
      end
      S_FETCH: if (pc_q >= CW'(len)) st_d = ST_HALT;
      S_EXEC:  cmd_d = p_rd;
      S_CELL: begin
        unique case (cmd_q)
          ChLeft:  if (dp_q == '0) st_d = ST_UNDER;
                   else begin dp_d = dp_q - (TW+1)'(1); pc_d = pc_inc; end
          ChRight: if (dp_q >= (TW+1)'(TAPE_DEPTH - 1)) st_d = ST_OVER;
                   else begin dp_d = dp_q + (TW+1)'(1); pc_d = pc_inc; end
          ChOpen: begin
            if (t_rd == 8'd0) begin idx_d = pc_inc; depth_d = CW'(1); end
            else if (sp_q >= DW'(STACK_DEPTH)) st_d = ST_STACK;
            else begin k_we = 1'b1; sp_d = sp_q + DW'(1); pc_d = pc_inc; end
          end
          ChClose: begin
            if (sp_q == '0) st_d = ST_BRACKET;
            else if (t_rd == 8'd0) begin sp_d = sp_q - DW'(1); pc_d = pc_inc; end
          end
          ChDot: begin
            res_d.out_valid = 1'b1; res_d.out_char = t_rd; pc_d = pc_inc;
          end
          ChPlus, ChMinus: cmd_d = t_rd;
          default: pc_d = pc_inc;
        endcase
        if ((cmd_q == ChPlus) || (cmd_q == ChMinus)) cmd_d = cmd_q;
      end
      S_WRITE: begin
        t_we = 1'b1;
        t_wd = (cmd_q == ChPlus) ? t_rd + 8'd1 : t_rd - 8'd1;
        pc_d = pc_inc;
      end
      S_POP: pc_d = CW'(k_rd) + CW'(1);
      S_SKIP_RD: begin
        p_ra = idx_q[PW-1:0];
        if (idx_q >= CW'(len)) st_d = ST_BRACKET;
      end
      S_SKIP: begin
        idx_d = idx_q + CW'(1);
        if (p_rd == ChOpen) depth_d = depth_q + CW'(1);
        else if (p_rd == ChClose) begin
          depth_d = depth_q - CW'(1);
          if (depth_q == CW'(1)) pc_d = idx_q + CW'(1);
        end
      end
      S_OUT: mval_d = 1'b1;
      default: ;
    endcase
    if (state_d == S_OUT) begin
      res_d.status          = st_d;
      res_d.program_counter = 13'(pc_d);
      res_d.tape_pointer    = 15'(dp_d);
    end
  end

  // tape read is kept for the cell state; write-back reuses t_rd, which still holds the cell
  // as the tape read port stays on the same address through S_WRITE

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; plen_q <= '0; pc_q <= '0; dp_q <= '0; sp_q <= '0;
      st_q <= ST_RUN; busy_q <= 1'b1; fresh_q <= 1'b0; mval_q <= 1'b0;
      clr_q <= '0; idx_q <= '0; depth_q <= '0;
    end else begin
      state_q <= state_d; pc_q <= pc_d; dp_q <= dp_d; sp_q <= sp_d; st_q <= st_d;
      busy_q <= busy_d; fresh_q <= fresh_d;
      mval_q <= mval_d; clr_q <= clr_d; idx_q <= idx_d; depth_q <= depth_d;
      if (cfg_we_i) plen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

`include "brainfuck_interpreter_core_assert.svh"
  `BFI_ASSERT_IMP(a_no_accept_busy, mval_q, !s_axis_tready, "accepted while result pending")
  `BFI_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= DW'(STACK_DEPTH), "stack depth out of range")
  `BFI_ASSERT_NEXT(a_out_follows, state_q == S_OUT, mval_q, "result not registered")
  `BFI_ASSERT_IMP(a_dp_bound, 1'b1, dp_q < (TW+1)'(TAPE_DEPTH), "pointer out of range")
endmodule
`default_nettype wire

FILE: bench/brainfuck_interpreter_core_tb.sv
`timescale 1ns / 1ps
module brainfuck_interpreter_core_tb;
  import bfi_pkg::*;

  localparam int ProgDepth = 4096;
  localparam int TapeDepth = 32768;
  localparam int StackDepth = 64;
  localparam int CycleLimit = 4000000;

  typedef struct {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
  } bf_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;

  brainfuck_interpreter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // shadow interpreter state
  logic [7:0]  prog_mem [ProgDepth];
  logic [7:0]  tape_mem [TapeDepth];
  int          pc_q;
  int          ptr_q;
  int          loop_starts [StackDepth];
  int          open_loops;
  status_e     run_status;
  int          prog_len_cfg;

  bf_cmd_t     cmd_queue [$];
  result_t     expected_results [$];
  int          errors;
  int          cycles;
  int          n_sent;
  int          n_done;
  int          n_prints;
  int          n_restarts;
  bit          steady;
  int          hold_left;
  bit          in_taken;
  bit          out_taken;
  int          in_gap;
  int          out_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_len();
    return (prog_len_cfg > ProgDepth) ? ProgDepth : prog_len_cfg;
  endfunction

  task automatic restart_interp();
    int len;
    int depth;
    bit bad;
    len = eff_len();
    depth = 0;
    bad = 1'b0;
    for (int i = 0; i < TapeDepth; i++) tape_mem[i] = 8'd0;
    pc_q = 0;
    ptr_q = 0;
    open_loops = 0;
    for (int i = 0; i < len && !bad; i++) begin
      if (prog_mem[i] == ChOpen) depth++;
      else if (prog_mem[i] == ChClose) begin
        if (depth == 0) bad = 1'b1;
        else depth--;
      end
    end
    if (depth != 0) bad = 1'b1;
    run_status = bad ? ST_BRACKET : ST_RUN;
  endtask

  task automatic exec_command(output logic printed, output logic [7:0] ch);
    int len;
    int depth;
    int i;
    logic [7:0] cur_val;
    logic [7:0] op;
    printed = 1'b0;
    ch = 8'd0;
    len = eff_len();
    if (run_status != ST_RUN) return;
    if (pc_q >= len) begin
      run_status = ST_HALT;
      return;
    end
    op = prog_mem[pc_q];
    cur_val = tape_mem[ptr_q];
    case (op)
      ChPlus:  tape_mem[ptr_q] = cur_val + 8'd1;
      ChMinus: tape_mem[ptr_q] = cur_val - 8'd1;
      ChLeft: begin
        if (ptr_q == 0) begin
          run_status = ST_UNDER;
          return;
        end
        ptr_q--;
      end
      ChRight: begin
        if (ptr_q >= TapeDepth - 1) begin
          run_status = ST_OVER;
          return;
        end
        ptr_q++;
      end
      ChOpen: begin
        if (cur_val == 8'd0) begin
          // jump past the matching close bracket
          depth = 1;
          for (i = pc_q + 1; i < len; i++) begin
            if (prog_mem[i] == ChOpen) depth++;
            else if (prog_mem[i] == ChClose) begin
              depth--;
              if (depth == 0) break;
            end
          end
          if (i >= len) run_status = ST_BRACKET;
          else pc_q = i + 1;
          return;
        end
        if (open_loops >= StackDepth) begin
          run_status = ST_STACK;
          return;
        end
        loop_starts[open_loops] = pc_q;
        open_loops++;
      end
      ChClose: begin
        if (open_loops == 0) begin
          run_status = ST_BRACKET;
          return;
        end
        if (cur_val != 8'd0) begin
          pc_q = loop_starts[open_loops - 1] + 1;
          return;
        end
        open_loops--;
      end
      ChDot: begin
        printed = 1'b1;
        ch = cur_val;
      end
      default: ;
    endcase
    pc_q++;
  endtask

  task automatic predict_result(input bf_cmd_t c);
    result_t r;
    logic printed;
    logic [7:0] ch;
    printed = 1'b0;
    ch = 8'd0;
    case (c.op)
      OP_LOAD:    prog_mem[c.addr] = c.data;
      OP_STEP:    exec_command(printed, ch);
      OP_RESTART: restart_interp();
      default: ;
    endcase
    r.out_valid = printed;
    r.out_char = ch;
    r.status = run_status;
    r.program_counter = pc_q[12:0];
    r.tape_pointer = ptr_q[14:0];
    expected_results.push_back(r);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_result('{s_axis_tdata[1:0], s_axis_tdata[13:2], s_axis_tdata[21:14]});
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    bf_cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap = steady ? 0 : $urandom_range(0, 7);
      end
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        s_axis_tdata <= {2'b00, c.data, c.addr, c.op};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    result_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("brainfuck_interpreter_core regression: fail");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_taken = 1'b1;
      n_done++;
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tdata[0] !== e.out_valid) begin
          $error("out_valid expected %0d got %0d", e.out_valid, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[8:1] !== e.out_char) begin
          $error("out_char expected %0d got %0d", e.out_char, m_axis_tdata[8:1]);
          errors++;
        end
        if (m_axis_tdata[11:9] !== e.status) begin
          $error("status expected %0d got %0d", e.status, m_axis_tdata[11:9]);
          errors++;
        end
        if (m_axis_tdata[24:12] !== e.program_counter) begin
          $error("program_counter expected %0d got %0d", e.program_counter,
                 m_axis_tdata[24:12]);
          errors++;
        end
        if (m_axis_tdata[39:25] !== e.tape_pointer) begin
          $error("tape_pointer expected %0d got %0d", e.tape_pointer, m_axis_tdata[39:25]);
          errors++;
        end
        if (e.out_valid) n_prints++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_stall = steady ? 0 : $urandom_range(0, 7);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send(input op_e op, input int addr, input logic [7:0] data);
    cmd_queue.push_back('{op, addr[11:0], data});
    if (op == OP_RESTART) n_restarts++;
    n_sent++;
  endtask

  task automatic wait_idle();
    while (n_done < n_sent) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_length(input int len);
    wait_idle();
    cfg_wdata_i <= len[12:0];
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    prog_len_cfg = len;
  endtask

  task automatic load_text(input logic [7:0] text [$]);
    foreach (text[i]) send(OP_LOAD, i, text[i]);
  endtask

  function automatic logic [7:0] pick_plain();
    case ($urandom_range(0, 9))
      0, 1, 2: return ChPlus;
      3:       return ChMinus;
      4, 5:    return ChRight;
      6:       return ChLeft;
      7, 8:    return ChDot;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed bracket nesting with random commands inside
  task automatic make_program(input int len, input bit broken, output logic [7:0] text [$]);
    int depth;
    int left;
    text = {};
    depth = 0;
    for (int i = 0; i < len; i++) begin
      left = len - i;
      if (broken) begin
        case ($urandom_range(0, 4))
          0:       text.push_back(ChOpen);
          1:       text.push_back(ChClose);
          default: text.push_back(pick_plain());
        endcase
      end else if (left == depth) begin
        text.push_back(ChClose);
        depth--;
      end else if (depth < 4 && left > depth + 2 && $urandom_range(0, 5) == 0) begin
        text.push_back(ChOpen);
        depth++;
      end else if (depth > 0 && $urandom_range(0, 5) == 0) begin
        text.push_back(ChClose);
        depth--;
      end else begin
        text.push_back(pick_plain());
      end
    end
  endtask

  initial begin
    logic [7:0] text [$];
    int len;
    int n_steps;
    errors = 0;
    cycles = 0;
    n_sent = 0;
    n_done = 0;
    n_prints = 0;
    n_restarts = 0;
    steady = 1'b0;
    hold_left = 0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    in_gap = 0;
    out_stall = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    prog_len_cfg = 0;
    pc_q = 0;
    ptr_q = 0;
    open_loops = 0;
    run_status = ST_RUN;
    for (int i = 0; i < TapeDepth; i++) tape_mem[i] = 8'd0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty program: field extremes, unknown op, restart then halt
    send(OP_NONE, 0, 8'd0);
    send(OP_LOAD, 4095, 8'hFF);
    send(OP_LOAD, 0, 8'h00);
    send(OP_NONE, 4095, 8'hFF);
    send(OP_RESTART, 0, 8'd0);
    send(OP_STEP, 0, 8'd0);
    send(OP_STEP, 0, 8'd0);

    // loop skip that runs off the end once the close bracket is overwritten
    set_length(3);
    load_text('{ChOpen, ChClose, ChDot});
    send(OP_RESTART, 0, 8'd0);
    send(OP_LOAD, 1, ChPlus);
    send(OP_STEP, 0, 8'd0);
    send(OP_STEP, 0, 8'd0);

    // close bracket with nothing open, patched in after the check
    load_text('{ChPlus, ChMinus, ChDot});
    send(OP_RESTART, 0, 8'd0);
    send(OP_LOAD, 0, ChClose);
    send(OP_STEP, 0, 8'd0);

    // pointer below cell zero
    set_length(2);
    load_text('{ChLeft, ChPlus});
    send(OP_RESTART, 0, 8'd0);
    send(OP_STEP, 0, 8'd0);
    send(OP_STEP, 0, 8'd0);

    // loop nesting one deeper than the stack holds
    set_length(2 * StackDepth + 3);
    text = {ChPlus};
    for (int i = 0; i <= StackDepth; i++) text.push_back(ChOpen);
    for (int i = 0; i <= StackDepth; i++) text.push_back(ChClose);
    text.push_back(ChDot);
    load_text(text);
    send(OP_RESTART, 0, 8'd0);
    for (int i = 0; i < StackDepth + 3; i++) send(OP_STEP, 0, 8'd0);

    // lengths at and beyond the store size, loads and one unknown op only
    set_length(ProgDepth);
    for (int i = 0; i < 8; i++) send(OP_LOAD, $urandom_range(0, 4095), 8'($urandom));
    set_length(8191);
    for (int i = 0; i < 8; i++) send(OP_LOAD, $urandom_range(0, 4095), 8'($urandom));
    send(OP_NONE, 0, 8'd0);

    for (int ph = 0; ph < 17; ph++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 40);
      set_length(len);
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        @(posedge clk_i);
        hold_left = 400;
      end
      make_program(len, $urandom_range(0, 5) == 0, text);
      load_text(text);
      send(OP_RESTART, 0, 8'd0);
      n_steps = $urandom_range(30, 60);
      for (int i = 0; i < n_steps; i++) begin
        case ($urandom_range(0, 19))
          0:       send(OP_LOAD, $urandom_range(0, len - 1), pick_plain());
          1:       send(OP_LOAD, $urandom_range(0, 4095), 8'($urandom));
          2:       send(OP_NONE, $urandom_range(0, 4095), 8'($urandom));
          default: send(OP_STEP, $urandom_range(0, 4095), 8'($urandom));
        endcase
      end
    end

    wait_idle();
    repeat (50) @(negedge clk_i);
    $display("covered %0d transactions, %0d restarts, %0d printed characters",
             n_sent, n_restarts, n_prints);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("brainfuck_interpreter_core regression: pass");
    end else begin
      $display("brainfuck_interpreter_core regression: fail");
    end
    $finish;
  end
endmodule
